[rtl/ash_pkg.sv]
// Shared types, constants and the arctangent table for the angle sector hit test.
`timescale 1ns / 1ps
`default_nettype none
package ash_pkg;

  // CORDIC datapath width: offsets are scaled to 2^58 at most and grow by the CORDIC gain.
  localparam int DW = 62;
  // Offsets are scaled by 2^(SCALE_BASE - coordinate width).
  localparam int SCALE_BASE = 58;
  // Angle accumulator width in 1/65536 degree.
  localparam int ZW = 27;
  // Output angle width in 1/16 degree.
  localparam int AW = 13;
  localparam int TURN = 5760;
  localparam int HALF_TURN = 2880;
  localparam logic signed [ZW-1:0] HALF_TURN_FINE = ZW'(180 * 65536);
  localparam logic signed [ZW-1:0] ROUND_BIAS = ZW'(2048);

  // Configuration register indexes.
  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_MODE = 2'd1;
  localparam logic [1:0] REG_SPAN = 2'd2;

  // Flags that travel beside the CORDIC chains.
  typedef struct packed {
    logic valid;
    logic degen;
  } side_t;

  // Rounded atan(2^-i) in 1/65536 degree.
  function automatic logic signed [ZW-1:0] atan_fine(input int idx);
    logic signed [ZW-1:0] v;
    begin
      case (idx)
        0: v = ZW'(2949120);
        1: v = ZW'(1740967);
        2: v = ZW'(919879);
        3: v = ZW'(466945);
        4: v = ZW'(234379);
        5: v = ZW'(117304);
        6: v = ZW'(58666);
        7: v = ZW'(29335);
        8: v = ZW'(14668);
        9: v = ZW'(7334);
        10: v = ZW'(3667);
        11: v = ZW'(1833);
        12: v = ZW'(917);
        13: v = ZW'(458);
        14: v = ZW'(229);
        15: v = ZW'(115);
        16: v = ZW'(57);
        17: v = ZW'(29);
        18: v = ZW'(14);
        19: v = ZW'(7);
        20: v = ZW'(4);
        21: v = ZW'(2);
        22: v = ZW'(1);
        default: v = '0;
      endcase
      return v;
    end
  endfunction

endpackage
`default_nettype wire

[rtl/angle_sector_hit_test.sv]
// Angle sector hit test: three parallel CORDIC chains, radius check and sweep test.
// Throughput: one request per cycle; the pipeline advances whenever the output
// register is empty or its result is taken, and the whole pipeline stalls otherwise.
// Reset (rst, synchronous) clears all valid bits and loads radius 20, mode 0, span 0.
`timescale 1ns / 1ps
`default_nettype none
module angle_sector_hit_test #(
  parameter int COORD_WIDTH = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        s_tvalid,
  output logic                       s_tready,
  // vertex_x, vertex_y, arm1_x, arm1_y, arm2_x, arm2_y, query_x, query_y
  input  wire [8*COORD_WIDTH-1:0]    s_tdata,
  output logic                       m_tvalid,
  input  wire                        m_tready,
  // start_angle[12:0], span_angle[25:13], hit[26], degenerate[27], zeros[31:28]
  output logic [31:0]                m_tdata,
  input  wire                        cfg_we,
  input  wire [1:0]                  cfg_index,
  input  wire [12:0]                 cfg_data
);

  localparam int CW = COORD_WIDTH;
  localparam int AW = ash_pkg::AW;
  localparam int SQW = 2 * CW + 2;

  // Configuration registers.
  logic [11:0]          sector_radius;
  logic                 fixed_span_mode;
  logic signed [AW-1:0] fixed_span;
  logic [23:0]          rad2;

  always_ff @(posedge clk) begin
    if (rst) begin
      sector_radius <= 12'd20;
      fixed_span_mode <= 1'b0;
      fixed_span <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ash_pkg::REG_RADIUS: sector_radius <= cfg_data[11:0];
        ash_pkg::REG_MODE: fixed_span_mode <= cfg_data[0];
        ash_pkg::REG_SPAN: fixed_span <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rad2 <= sector_radius * sector_radius;
  end

  // Pipeline advance.
  logic en;
  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  // Stage 1: offsets from the vertex and zero flags.
  logic signed [CW:0] vx, vy, ax, ay, bx, by, qx, qy;
  logic signed [CW:0] ax1, ay1, bx1, by1, qx1, qy1;
  ash_pkg::side_t side [0:CORDIC_STAGES+2];

  assign vx = (CW+1)'($signed(s_tdata[0*CW +: CW]));
  assign vy = (CW+1)'($signed(s_tdata[1*CW +: CW]));
  assign ax = (CW+1)'($signed(s_tdata[2*CW +: CW])) - vx;
  assign ay = (CW+1)'($signed(s_tdata[3*CW +: CW])) - vy;
  assign bx = (CW+1)'($signed(s_tdata[4*CW +: CW])) - vx;
  assign by = (CW+1)'($signed(s_tdata[5*CW +: CW])) - vy;
  assign qx = (CW+1)'($signed(s_tdata[6*CW +: CW])) - vx;
  assign qy = (CW+1)'($signed(s_tdata[7*CW +: CW])) - vy;

  always_ff @(posedge clk) begin
    if (rst) begin
      side[0].valid <= 1'b0;
    end else if (en) begin
      side[0].valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax1 <= ax;
      ay1 <= ay;
      bx1 <= bx;
      by1 <= by;
      qx1 <= qx;
      qy1 <= qy;
      side[0].degen <= ((ax == '0) && (ay == '0)) || ((qx == '0) && (qy == '0)) ||
                       (!fixed_span_mode && (bx == '0) && (by == '0));
    end
  end

  // Side flags delayed to meet the direction outputs.
  for (genvar i = 0; i < CORDIC_STAGES + 2; i++) begin : g_side
    always_ff @(posedge clk) begin
      if (rst) begin
        side[i+1].valid <= 1'b0;
      end else if (en) begin
        side[i+1].valid <= side[i].valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side[i+1].degen <= side[i].degen;
      end
    end
  end

  // Squared distance of the query, then the radius compare.
  logic [SQW-1:0] sqx, sqy;
  logic [SQW:0]   d2;
  logic           in_rad [0:CORDIC_STAGES];

  assign d2 = {1'b0, sqx} + {1'b0, sqy};

  always_ff @(posedge clk) begin
    if (en) begin
      sqx <= $unsigned(SQW'(qx1) * SQW'(qx1));
      sqy <= $unsigned(SQW'(qy1) * SQW'(qy1));
      in_rad[0] <= d2 <= (SQW+1)'(rad2);
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rad
    always_ff @(posedge clk) begin
      if (en) begin
        in_rad[i+1] <= in_rad[i];
      end
    end
  end

  // Three direction chains.
  logic signed [AW-1:0] ang_a, ang_b, ang_q;

  ash_direction #(.COORD_WIDTH(CW), .CORDIC_STAGES(CORDIC_STAGES)) u_dir_a (
    .clk(clk), .en(en), .dx(ax1), .dy(ay1), .angle(ang_a)
  );
  ash_direction #(.COORD_WIDTH(CW), .CORDIC_STAGES(CORDIC_STAGES)) u_dir_b (
    .clk(clk), .en(en), .dx(bx1), .dy(by1), .angle(ang_b)
  );
  ash_direction #(.COORD_WIDTH(CW), .CORDIC_STAGES(CORDIC_STAGES)) u_dir_q (
    .clk(clk), .en(en), .dx(qx1), .dy(qy1), .angle(ang_q)
  );

  // Sweep and query angle relative to the first arm.
  logic signed [AW:0]   span_diff, span_pick, rel_diff;
  logic signed [AW-1:0] span_fold;
  logic signed [AW-1:0] start_b, span_b;
  logic [AW-1:0]        rel_b;
  logic                 valid_b, degen_b, rad_b;

  always_comb begin
    span_diff = fixed_span_mode ? (AW+1)'(fixed_span)
                                : (AW+1)'(ang_b) - (AW+1)'(ang_a);
    if (span_diff > (AW+1)'(ash_pkg::HALF_TURN)) begin
      span_pick = span_diff - (AW+1)'(ash_pkg::TURN);
    end else if (span_diff < -(AW+1)'(ash_pkg::HALF_TURN)) begin
      span_pick = span_diff + (AW+1)'(ash_pkg::TURN);
    end else begin
      span_pick = span_diff;
    end
    span_fold = AW'(span_pick);
    rel_diff = (AW+1)'(ang_q) - (AW+1)'(ang_a);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_b <= 1'b0;
    end else if (en) begin
      valid_b <= side[CORDIC_STAGES+2].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      start_b <= ang_a;
      span_b <= span_fold;
      rel_b <= rel_diff[AW] ? AW'(rel_diff + (AW+1)'(ash_pkg::TURN)) : AW'(rel_diff);
      degen_b <= side[CORDIC_STAGES+2].degen;
      rad_b <= in_rad[CORDIC_STAGES];
    end
  end

  // Strict inside test and the output register.
  logic [AW:0] rel_back;
  logic [AW:0] span_mag;
  logic        in_sweep;

  always_comb begin
    rel_back = (AW+1)'(ash_pkg::TURN) - (AW+1)'(rel_b);
    span_mag = (AW+1)'($unsigned(-((AW+1)'(span_b))));
    if (span_b == '0) begin
      in_sweep = 1'b0;
    end else if (!span_b[AW-1]) begin
      in_sweep = (rel_b != '0) && ($signed({1'b0, rel_b}) < $signed((AW+1)'(span_b)));
    end else begin
      in_sweep = (rel_b != '0) && (rel_back < span_mag);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= valid_b;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {4'b0000, degen_b, !degen_b && rad_b && in_sweep, span_b, start_b};
    end
  end

endmodule
`default_nettype wire

[rtl/ash_cordic_cell.sv]
// One vectoring CORDIC cell: a single micro-rotation with a registered result.
`timescale 1ns / 1ps
`default_nettype none
module ash_cordic_cell #(
  parameter int STAGE = 0
) (
  input  wire                                   clk,
  input  wire                                   en,
  input  wire logic signed [ash_pkg::DW-1:0]    x_in,
  input  wire logic signed [ash_pkg::DW-1:0]    y_in,
  input  wire logic signed [ash_pkg::ZW-1:0]    z_in,
  output logic signed [ash_pkg::DW-1:0]         x_out,
  output logic signed [ash_pkg::DW-1:0]         y_out,
  output logic signed [ash_pkg::ZW-1:0]         z_out
);

  localparam logic signed [ash_pkg::ZW-1:0] ATAN = ash_pkg::atan_fine(STAGE);

  logic signed [ash_pkg::DW-1:0] xs;
  logic signed [ash_pkg::DW-1:0] ys;

  assign xs = x_in >>> STAGE;
  assign ys = y_in >>> STAGE;

  // Rotate toward y = 0; a zero y counts as non-negative.
  always_ff @(posedge clk) begin
    if (en) begin
      if (!y_in[ash_pkg::DW-1]) begin
        x_out <= x_in + ys;
        y_out <= y_in - xs;
        z_out <= z_in + ATAN;
      end else begin
        x_out <= x_in - ys;
        y_out <= y_in + xs;
        z_out <= z_in - ATAN;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/ash_direction.sv]
// Direction of an offset vector with y flipped, in 1/16 degree, by a chain of CORDIC cells.
`timescale 1ns / 1ps
`default_nettype none
module ash_direction #(
  parameter int COORD_WIDTH = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  wire                                  clk,
  input  wire                                  en,
  input  wire logic signed [COORD_WIDTH:0]     dx,
  input  wire logic signed [COORD_WIDTH:0]     dy,
  output logic signed [ash_pkg::AW-1:0]        angle
);

  localparam int SCALE = ash_pkg::SCALE_BASE - COORD_WIDTH;

  logic signed [ash_pkg::DW-1:0] xc [0:CORDIC_STAGES];
  logic signed [ash_pkg::DW-1:0] yc [0:CORDIC_STAGES];
  logic signed [ash_pkg::ZW-1:0] zc [0:CORDIC_STAGES];
  logic                          zero [0:CORDIC_STAGES];

  logic signed [ash_pkg::DW-1:0] dx_s;
  logic signed [ash_pkg::DW-1:0] dy_s;
  logic signed [ash_pkg::ZW-1:0] z_round;
  logic signed [ash_pkg::ZW-13:0] a_raw;
  logic signed [ash_pkg::ZW-13:0] a_lo;
  logic signed [ash_pkg::ZW-13:0] a_fold;

  assign dx_s = ash_pkg::DW'(dx) <<< SCALE;
  assign dy_s = ash_pkg::DW'(dy) <<< SCALE;

  // Turn a vector in the left half plane by half a turn before the chain.
  always_ff @(posedge clk) begin
    if (en) begin
      zero[0] <= (dx == '0) && (dy == '0);
      if (dx[COORD_WIDTH]) begin
        xc[0] <= -dx_s;
        yc[0] <= dy_s;
        zc[0] <= (dy <= 0) ? ash_pkg::HALF_TURN_FINE : -ash_pkg::HALF_TURN_FINE;
      end else begin
        xc[0] <= dx_s;
        yc[0] <= -dy_s;
        zc[0] <= '0;
      end
    end
  end

  // The chain of micro-rotations, with the zero-vector flag alongside.
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    ash_cordic_cell #(.STAGE(i)) u_cell (
      .clk  (clk),
      .en   (en),
      .x_in (xc[i]),
      .y_in (yc[i]),
      .z_in (zc[i]),
      .x_out(xc[i+1]),
      .y_out(yc[i+1]),
      .z_out(zc[i+1])
    );

    always_ff @(posedge clk) begin
      if (en) begin
        zero[i+1] <= zero[i];
      end
    end
  end

  // Round to 1/16 degree and fold into (-2880, 2880].
  always_comb begin
    z_round = zc[CORDIC_STAGES] + ash_pkg::ROUND_BIAS;
    a_raw = z_round[ash_pkg::ZW-1:12];
    a_lo = (a_raw <= -(ash_pkg::ZW-12)'(ash_pkg::HALF_TURN))
           ? a_raw + (ash_pkg::ZW-12)'(ash_pkg::TURN) : a_raw;
    a_fold = (a_lo > (ash_pkg::ZW-12)'(ash_pkg::HALF_TURN))
             ? a_lo - (ash_pkg::ZW-12)'(ash_pkg::TURN) : a_lo;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle <= zero[CORDIC_STAGES] ? '0 : ash_pkg::AW'(a_fold);
    end
  end

endmodule
`default_nettype wire
